@@ rtl/ckp_pkg.sv @@
// shared types and constants for the controller / keyboard port block
package ckp_pkg;

    localparam int unsigned HAND_KEYS    = 15;
    localparam int unsigned HAND_ENTRIES = 17;
    localparam int unsigned KEY_ROWS     = 8;
    localparam int unsigned KEY_BITS     = 24;

    // operation codes carried in tuser
    localparam logic [2:0] OP_READ     = 3'd0;
    localparam logic [2:0] OP_WRITE    = 3'd1;
    localparam logic [2:0] OP_TICK     = 3'd2;
    localparam logic [2:0] OP_SET_HAND = 3'd3;
    localparam logic [2:0] OP_SET_KEY  = 3'd4;

    // bus register addresses
    localparam logic [3:0] ADDR_CTRL    = 4'd8;
    localparam logic [3:0] ADDR_PORT_LO = 4'd14;
    localparam logic [4:0] HAND_LAST    = 5'd16;

    // disc encoding constants
    localparam logic [7:0] DISC_DIR_MASK  = 8'h14;
    localparam logic [7:0] DISC_DIR_MATCH = 8'h10;
    localparam logic [7:0] DISC_LOW_MASK  = 8'h0F;
    localparam logic [7:0] DISC_DIAG_SET  = 8'h64;

    // select-line bits that see the fake shift key
    localparam int unsigned SHIFT_ROW_SEL = 6;
    localparam int unsigned SHIFT_COL_SEL = 7;

    typedef logic [HAND_ENTRIES-1:0][7:0] t_hand_bank;
    typedef logic [KEY_ROWS-1:0][KEY_BITS-1:0] t_key_matrix;

    typedef struct packed {
        logic [7:0] port0;
        logic [7:0] port1;
        logic [1:0] shift_phase;
    } t_scan_state;

endpackage

@@ rtl/ckp_hand_eval.sv @@
// hand controller evaluation for one port: key OR, disc encode, invert
module ckp_hand_eval (
    input  ckp_pkg::t_hand_bank i_entries,
    output logic [7:0]          o_port_value
);
    import ckp_pkg::*;

    logic [7:0]  keys_or;
    logic [7:0]  disc;
    logic [11:0] df;
    logic [11:0] dsh;
    logic [7:0]  d;
    logic [4:0]  disc_bits;

    always_comb begin
        keys_or = '0;
        for (int i = 0; i < HAND_KEYS; i++) begin
            keys_or = keys_or | i_entries[i];
        end
        disc = i_entries[HAND_KEYS] | i_entries[HAND_KEYS+1];
        // flags moved up a nibble with the high nibble copied below, 12 bits wide
        df   = {disc, disc[7:4]};
        disc_bits = '0;
        // four overlapping windows walked two bits at a time
        for (int i = 0; i < 4; i++) begin
            dsh = df >> (2 * i);
            d   = dsh[7:0];
            if (((d & DISC_DIR_MASK) != DISC_DIR_MATCH) && ((d & DISC_LOW_MASK) > 8'h01)) begin
                disc_bits[i] = 1'b1;
            end
            if (DISC_DIAG_SET[d[2:0]]) begin
                disc_bits[4] = 1'b1;
            end
        end
        o_port_value = ~(keys_or | {3'b000, disc_bits});
    end

endmodule

@@ rtl/ckp_kbd_scan.sv @@
// keyboard matrix scan: normal or transposed, ghost masking, fake shift, synth keys
module ckp_kbd_scan (
    input  ckp_pkg::t_key_matrix i_key_matrix,
    input  logic [1:0]           i_port_is_output,
    input  ckp_pkg::t_scan_state i_state,
    output ckp_pkg::t_scan_state o_state
);
    import ckp_pkg::*;

    logic [KEY_BITS-1:0] any_key;
    logic [7:0]          kk    [KEY_ROWS];
    logic [7:0]          kk_sy [KEY_ROWS];
    logic [7:0]          tk    [KEY_ROWS];
    logic [1:0]          sp;
    logic [7:0]          sel;
    logic [7:0]          v;

    always_comb begin
        any_key = '0;
        for (int i = 0; i < KEY_ROWS; i++) begin
            any_key = any_key | i_key_matrix[i];
            kk[i] = i_state.shift_phase[0] ?
                    (i_key_matrix[i][7:0] | i_key_matrix[i][15:8]) : i_key_matrix[i][7:0];
            // synth bits are zero in every row when none is pressed
            kk_sy[i] = kk[i] | i_key_matrix[i][23:16];
        end
        for (int i = 0; i < KEY_ROWS; i++) begin
            for (int j = 0; j < KEY_ROWS; j++) begin
                tk[i][j] = kk[j][i];
            end
        end
        sp = (any_key[15:8] != 8'h00) ? (i_state.shift_phase | 2'b10) : 2'b00;

        o_state = i_state;
        v       = '0;
        sel     = '0;
        if (i_port_is_output[0] && i_port_is_output[1]) begin
            o_state.port0 = 8'hFF;
            o_state.port1 = 8'hFF;
        end else if (i_port_is_output[0]) begin
            sel = i_state.port0;
            for (int i = 0; i < KEY_ROWS; i++) begin
                if (!sel[i]) v = v | kk_sy[i];
            end
            if (!sel[SHIFT_ROW_SEL] && sp[1]) begin
                v[SHIFT_COL_SEL] = 1'b1;
                sp = 2'b01;
            end
            // ghost path masking
            for (int i = 0; i < KEY_ROWS; i++) begin
                if ((tk[i] & sel) != 8'h00) v[i] = 1'b0;
            end
            o_state.port1       = ~v;
            o_state.shift_phase = sp;
        end else begin
            sel = i_state.port1;
            for (int i = 0; i < KEY_ROWS; i++) begin
                if (!sel[i]) v = v | tk[i];
            end
            if (!sel[SHIFT_COL_SEL] && sp[1]) begin
                v[SHIFT_ROW_SEL] = 1'b1;
                sp = 2'b01;
            end
            for (int i = 0; i < KEY_ROWS; i++) begin
                if ((kk_sy[i] & sel) != 8'h00) v[i] = 1'b0;
            end
            o_state.port0       = ~v;
            o_state.shift_phase = sp;
        end
    end

endmodule

@@ rtl/controller_keyboard_port_model.sv @@
// top level: input register, port evaluation, state update and result register
//
// channel   direction  tvalid/tready             payload
// s_axis    in         i_s_axis_tvalid/o_..ready  tuser op, tdata bus/entry fields
// m_axis    out        o_m_axis_tvalid/i_..ready  tuser addr_claimed, tdata values
// cfg       in         i_cfg_valid/o_cfg_ready    i_cfg_data pad_mode
//
// an item waits in the input register and then leaves through the result
// register, where its result is offered; one item per cycle sustained while
// the result side takes each result
// all entries and the key matrix sit in flops and are combined combinationally
// a stalled result holds the input register, which holds the input side
// synchronous active-low reset restores ports to 0xFF and clears all entries
module controller_keyboard_port_model (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // op[2:0]
    input  logic [2:0]  i_s_axis_tuser,
    // addr[3:0], write_data[11:4], hand_port[12], hand_entry[17:13],
    // hand_value[25:18], key_row[28:26], key_value[52:29], zero pad[55:53]
    input  logic [55:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // addr_claimed[0]
    output logic        o_m_axis_tuser,
    // read_data[7:0], port0_value[15:8], port1_value[23:16]
    output logic [23:0] o_m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    // pad_mode
    input  logic        i_cfg_data
);
    import ckp_pkg::*;

    // input register
    logic        r_in_valid;
    logic [2:0]  r_in_op;
    logic [55:0] r_in_data;

    // result register
    logic        r_out_valid;
    logic        r_out_user;
    logic [23:0] r_out_data;

    // block state
    logic                r_pad_mode;
    logic [1:0][7:0]     r_port_value;
    logic [1:0]          r_port_is_output;
    logic [1:0]          r_shift_phase;
    logic                r_inputs_changed;
    t_hand_bank          r_entries [2];
    t_key_matrix         r_key_matrix;

    logic [1:0][7:0]     n_port_value;
    logic [1:0]          n_port_is_output;
    logic [1:0]          n_shift_phase;
    logic                n_inputs_changed;

    logic        adv;
    logic [3:0]  f_addr;
    logic [7:0]  f_wd;
    logic        f_hp;
    logic [4:0]  f_he;
    logic [7:0]  f_hv;
    logic [2:0]  f_kr;
    logic [23:0] f_kv;

    logic        is_port_addr;
    logic        ctrl_write;
    logic        reeval;
    logic        do_tick;
    logic [1:0]  eff_out;
    logic        eff_changed;
    logic [7:0]  hand_val [2];
    t_scan_state scan_in;
    t_scan_state scan_out;
    logic [1:0][7:0] tick_port;
    logic [1:0]  tick_sp;
    logic        tick_changed;
    logic [7:0]  rd;
    logic        claimed;

    assign adv             = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = 1'b1;

    assign f_addr = r_in_data[3:0];
    assign f_wd   = r_in_data[11:4];
    assign f_hp   = r_in_data[12];
    assign f_he   = r_in_data[17:13];
    assign f_hv   = r_in_data[25:18];
    assign f_kr   = r_in_data[28:26];
    assign f_kv   = r_in_data[52:29];

    assign is_port_addr = f_addr >= ADDR_PORT_LO;
    assign ctrl_write   = (r_in_op == OP_WRITE) && (f_addr == ADDR_CTRL);
    // a port turning back to input forces a fresh evaluation
    assign reeval       = ctrl_write && ((!f_wd[6] && r_port_is_output[0]) ||
                                         (!f_wd[7] && r_port_is_output[1]));
    assign eff_out      = ctrl_write ? f_wd[7:6] : r_port_is_output;
    assign eff_changed  = r_inputs_changed || reeval;
    assign do_tick      = ((r_in_op == OP_READ) && is_port_addr && r_pad_mode) ||
                          reeval || (r_in_op == OP_TICK);

    ckp_hand_eval u_hand0 (
        .i_entries    (r_entries[0]),
        .o_port_value (hand_val[0])
    );

    ckp_hand_eval u_hand1 (
        .i_entries    (r_entries[1]),
        .o_port_value (hand_val[1])
    );

    assign scan_in = '{port0: r_port_value[0], port1: r_port_value[1],
                       shift_phase: r_shift_phase};

    ckp_kbd_scan u_kbd (
        .i_key_matrix     (r_key_matrix),
        .i_port_is_output (eff_out),
        .i_state          (scan_in),
        .o_state          (scan_out)
    );

    // tick outcome, applied only when the item calls for one
    always_comb begin
        tick_port    = r_port_value;
        tick_sp      = r_shift_phase;
        tick_changed = eff_changed;
        if (r_pad_mode && (eff_out != 2'b00)) begin
            tick_port[0] = scan_out.port0;
            tick_port[1] = scan_out.port1;
            tick_sp      = scan_out.shift_phase;
        end else if (eff_changed) begin
            tick_changed = 1'b0;
            for (int s = 0; s < 2; s++) begin
                if (!eff_out[s]) tick_port[s] = hand_val[s];
            end
        end
    end

    always_comb begin
        n_port_value     = r_port_value;
        n_port_is_output = r_port_is_output;
        n_shift_phase    = r_shift_phase;
        n_inputs_changed = r_inputs_changed;
        if (do_tick) begin
            n_port_value     = tick_port;
            n_shift_phase    = tick_sp;
            n_inputs_changed = tick_changed;
        end
        rd      = 8'hFF;
        claimed = 1'b0;
        unique case (r_in_op)
            OP_READ: begin
                if (is_port_addr) begin
                    rd      = n_port_value[f_addr[0]];
                    claimed = 1'b1;
                end
            end
            OP_WRITE: begin
                if (ctrl_write) begin
                    n_port_is_output = f_wd[7:6];
                end
                if (is_port_addr && r_port_is_output[f_addr[0]]) begin
                    n_port_value[f_addr[0]] = f_wd;
                end
            end
            OP_TICK: begin
            end
            OP_SET_HAND: begin
                n_inputs_changed = 1'b1;
            end
            OP_SET_KEY: begin
                n_inputs_changed = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_op   <= i_s_axis_tuser;
            r_in_data <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_user <= claimed;
            r_out_data <= {n_port_value[1], n_port_value[0], rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_pad_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_value     <= {8'hFF, 8'hFF};
            r_port_is_output <= 2'b00;
            r_shift_phase    <= 2'b00;
            r_inputs_changed <= 1'b1;
        end else if (adv) begin
            r_port_value     <= n_port_value;
            r_port_is_output <= n_port_is_output;
            r_shift_phase    <= n_shift_phase;
            r_inputs_changed <= n_inputs_changed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries[0] <= '0;
            r_entries[1] <= '0;
            r_key_matrix <= '0;
        end else if (adv) begin
            if ((r_in_op == OP_SET_HAND) && (f_he <= HAND_LAST)) begin
                r_entries[f_hp][f_he] <= f_hv;
            end
            if (r_in_op == OP_SET_KEY) begin
                r_key_matrix[f_kr] <= f_kv;
            end
        end
    end

    // reset brings ports back to floating input with a pending evaluation
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_inputs_changed && (r_port_value == {8'hFF, 8'hFF}) &&
                      (r_port_is_output == 2'b00) && !r_in_valid && !r_out_valid))
        else $error("state not restored by reset");

    // an unclaimed result always reads back as all ones
    a_unclaimed_ff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_user) |-> (r_out_data[7:0] == 8'hFF))
        else $error("unclaimed read data not 0xFF");

    // a port write to an input-direction port leaves both ports alone
    a_port_write_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && (r_in_op == OP_WRITE) && is_port_addr && !r_port_is_output[f_addr[0]])
        |=> $stable(r_port_value))
        else $error("write to input port changed port value");

    // a held item is never dropped from the input register
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> (r_in_valid && $stable(r_in_data)))
        else $error("stalled item lost from input register");

endmodule

@@ tb/controller_keyboard_port_model_tb.sv @@
// self-checking testbench for the controller / keyboard port block
module controller_keyboard_port_model_tb;
    import ckp_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int REPORT_LIMIT = 60;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  addr;
        logic [7:0]  write_data;
        logic        hand_port;
        logic [4:0]  hand_entry;
        logic [7:0]  hand_value;
        logic [2:0]  key_row;
        logic [23:0] key_value;
    } t_bus_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       claimed;
        logic [7:0] port0;
        logic [7:0] port1;
    } t_port_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [2:0]  i_s_axis_tuser = '0;
    logic [55:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic        o_m_axis_tuser;
    logic [23:0] o_m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;

    // predicted copy of the block state
    logic        keyboard_mode;
    logic [7:0]  port_val [2];
    logic        port_drives [2];
    logic [1:0]  shift_seq;
    logic        pads_dirty;
    logic [7:0]  pad_entries [2][HAND_ENTRIES];
    logic [23:0] key_rows [KEY_ROWS];

    t_port_result expected_ports [$];
    int           mismatches = 0;
    int           stall_cycles = 0;
    int           src_idle_pct = 0;
    int           snk_idle_pct = 0;

    controller_keyboard_port_model uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic void clear_ports_model();
        keyboard_mode = 1'b0;
        port_val[0] = 8'hFF;
        port_val[1] = 8'hFF;
        port_drives[0] = 1'b0;
        port_drives[1] = 1'b0;
        shift_seq = 2'b00;
        pads_dirty = 1'b1;
        for (int p = 0; p < 2; p++)
            for (int e = 0; e < HAND_ENTRIES; e++)
                pad_entries[p][e] = 8'h00;
        for (int r = 0; r < KEY_ROWS; r++)
            key_rows[r] = '0;
    endfunction

    function automatic void refresh_pads();
        logic [7:0]  keys_or;
        logic [7:0]  flags;
        logic [11:0] disc;
        if (!pads_dirty)
            return;
        pads_dirty = 1'b0;
        for (int s = 0; s < 2; s++) begin
            if (!port_drives[s]) begin
                keys_or = 8'h00;
                for (int i = 0; i < HAND_KEYS; i++)
                    keys_or |= pad_entries[s][i];
                flags = pad_entries[s][15] | pad_entries[s][16];
                // high nibble copied below widens to 12 bits before the 2-bit walk
                disc = {flags, flags[7:4]};
                for (int i = 0; i < 4; i++) begin
                    if ((disc[7:0] & DISC_DIR_MASK) != DISC_DIR_MATCH &&
                        (disc[7:0] & DISC_LOW_MASK) > 8'd1)
                        keys_or[i] = 1'b1;
                    if (DISC_DIAG_SET[disc[2:0]])
                        keys_or[4] = 1'b1;
                    disc = disc >> 2;
                end
                port_val[s] = ~keys_or;
            end
        end
    endfunction

    function automatic void scan_keyboard();
        logic [7:0]  row_keys [KEY_ROWS];
        logic [7:0]  col_keys [KEY_ROWS];
        logic [23:0] held;
        logic [7:0]  sense;
        logic [7:0]  sel;
        logic        synth;
        if (port_drives[0] && port_drives[1]) begin
            port_val[0] = 8'hFF;
            port_val[1] = 8'hFF;
            return;
        end
        held = '0;
        for (int r = 0; r < KEY_ROWS; r++) begin
            row_keys[r] = shift_seq[0] ? (key_rows[r][7:0] | key_rows[r][15:8])
                                       : key_rows[r][7:0];
            held |= key_rows[r];
        end
        synth = |held[23:16];
        if (|held[15:8])
            shift_seq[1] = 1'b1;
        else
            shift_seq = 2'b00;
        for (int i = 0; i < KEY_ROWS; i++)
            for (int j = 0; j < KEY_ROWS; j++)
                col_keys[i][j] = row_keys[j][i];
        if (synth)
            for (int r = 0; r < KEY_ROWS; r++)
                row_keys[r] |= key_rows[r][23:16];
        sense = 8'h00;
        if (port_drives[0]) begin
            sel = port_val[0];
            for (int r = 0; r < KEY_ROWS; r++)
                if (!sel[r])
                    sense |= row_keys[r];
            if (!sel[SHIFT_ROW_SEL] && shift_seq[1]) begin
                sense[SHIFT_COL_SEL] = 1'b1;
                shift_seq = 2'b01;
            end
            // ghost paths through a deselected row
            for (int i = 0; i < KEY_ROWS; i++)
                if (|(col_keys[i] & sel))
                    sense[i] = 1'b0;
            port_val[1] = ~sense;
        end else begin
            sel = port_val[1];
            for (int c = 0; c < KEY_ROWS; c++)
                if (!sel[c])
                    sense |= col_keys[c];
            if (!sel[SHIFT_COL_SEL] && shift_seq[1]) begin
                sense[SHIFT_ROW_SEL] = 1'b1;
                shift_seq = 2'b01;
            end
            for (int i = 0; i < KEY_ROWS; i++)
                if (|(row_keys[i] & sel))
                    sense[i] = 1'b0;
            port_val[0] = ~sense;
        end
    endfunction

    function automatic void evaluate_ports();
        if (keyboard_mode && (port_drives[0] || port_drives[1]))
            scan_keyboard();
        else
            refresh_pads();
    endfunction

    function automatic t_port_result predict_ports(t_bus_item it);
        t_port_result res;
        logic         out0;
        logic         out1;
        logic         turned_input;
        res.read_data = 8'hFF;
        res.claimed = 1'b0;
        case (it.op)
            OP_READ: begin
                if (it.addr >= ADDR_PORT_LO) begin
                    if (keyboard_mode)
                        evaluate_ports();
                    res.read_data = port_val[it.addr[0]];
                    res.claimed = 1'b1;
                end
            end
            OP_WRITE: begin
                if (it.addr == ADDR_CTRL) begin
                    out0 = it.write_data[6];
                    out1 = it.write_data[7];
                    turned_input = (!out0 && port_drives[0]) || (!out1 && port_drives[1]);
                    port_drives[0] = out0;
                    port_drives[1] = out1;
                    if (turned_input) begin
                        pads_dirty = 1'b1;
                        evaluate_ports();
                    end
                end
                if (it.addr >= ADDR_PORT_LO && port_drives[it.addr[0]])
                    port_val[it.addr[0]] = it.write_data;
            end
            OP_TICK:
                evaluate_ports();
            OP_SET_HAND: begin
                if (it.hand_entry <= HAND_LAST)
                    pad_entries[it.hand_port][it.hand_entry] = it.hand_value;
                pads_dirty = 1'b1;
            end
            OP_SET_KEY: begin
                key_rows[it.key_row] = it.key_value;
                pads_dirty = 1'b1;
            end
            default: ;
        endcase
        res.port0 = port_val[0];
        res.port1 = port_val[1];
        return res;
    endfunction

    function automatic t_bus_item noise_item();
        t_bus_item it;
        it.op = 3'($urandom);
        it.addr = 4'($urandom);
        it.write_data = 8'($urandom);
        it.hand_port = 1'($urandom);
        it.hand_entry = 5'($urandom);
        it.hand_value = 8'($urandom);
        it.key_row = 3'($urandom);
        it.key_value = 24'($urandom);
        return it;
    endfunction

    function automatic logic [7:0] sparse_byte();
        case ($urandom_range(3))
            0, 1: return 8'h00;
            2: return 8'h01 << $urandom_range(7);
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_bus_item traffic_item();
        t_bus_item   it;
        int unsigned pick;
        it = noise_item();
        pick = $urandom_range(99);
        if (pick < 30) begin
            it.op = OP_READ;
            if ($urandom_range(9) != 0)
                it.addr[3:1] = 3'b111;
        end else if (pick < 55) begin
            it.op = OP_WRITE;
            case ($urandom_range(9))
                0, 1, 2: it.addr = ADDR_CTRL;
                3: ;
                default: it.addr[3:1] = 3'b111;
            endcase
            // about half of the port writes put a single select line low
            if (it.addr[3:1] == 3'b111 && $urandom_range(1))
                it.write_data = ~(8'h01 << $urandom_range(7));
        end else if (pick < 70) begin
            it.op = OP_TICK;
        end else if (pick < 82) begin
            it.op = OP_SET_HAND;
            if ($urandom_range(9) != 0)
                it.hand_entry = 5'($urandom_range(HAND_LAST));
            if ($urandom_range(99) < 70)
                it.hand_value = 8'h00;
        end else if (pick < 95) begin
            it.op = OP_SET_KEY;
            it.key_value = {sparse_byte(), sparse_byte(), sparse_byte()};
        end else begin
            it.op = 3'($urandom_range(7, 5));
        end
        return it;
    endfunction

    task automatic send_item(t_bus_item it);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= it.op;
        i_s_axis_tdata <= {3'b000, it.key_value, it.key_row, it.hand_value, it.hand_entry,
                           it.hand_port, it.write_data, it.addr};
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_ports.push_back(predict_ports(it));
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_ports.size() != 0);
    endtask

    task automatic set_pad_mode(logic mode);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        keyboard_mode = mode;
    endtask

    task automatic bus_read(logic [3:0] addr);
        t_bus_item it;
        it = noise_item();
        it.op = OP_READ;
        it.addr = addr;
        send_item(it);
    endtask

    task automatic bus_write(logic [3:0] addr, logic [7:0] data);
        t_bus_item it;
        it = noise_item();
        it.op = OP_WRITE;
        it.addr = addr;
        it.write_data = data;
        send_item(it);
    endtask

    task automatic send_plain(logic [2:0] op);
        t_bus_item it;
        it = noise_item();
        it.op = op;
        send_item(it);
    endtask

    task automatic set_pad(logic port, logic [4:0] entry, logic [7:0] value);
        t_bus_item it;
        it = noise_item();
        it.op = OP_SET_HAND;
        it.hand_port = port;
        it.hand_entry = entry;
        it.hand_value = value;
        send_item(it);
    endtask

    task automatic set_row(logic [2:0] row, logic [23:0] value);
        t_bus_item it;
        it = noise_item();
        it.op = OP_SET_KEY;
        it.key_row = row;
        it.key_value = value;
        send_item(it);
    endtask

    task automatic compare_field(string what, logic [7:0] got, logic [7:0] want);
        if (got !== want) begin
            if (mismatches < REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %02h, got %02h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // result side: random backpressure and in-order compare
    always @(posedge i_clk) begin : take_results
        t_port_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_ports.size() == 0) begin
                if (mismatches < REPORT_LIMIT)
                    $display("%0t: unexpected result, expected none, got %h/%b", $time,
                             o_m_axis_tdata, o_m_axis_tuser);
                mismatches++;
            end else begin
                want = expected_ports.pop_front();
                compare_field("read_data", o_m_axis_tdata[7:0], want.read_data);
                compare_field("addr_claimed", {7'd0, o_m_axis_tuser}, {7'd0, want.claimed});
                compare_field("port0_value", o_m_axis_tdata[15:8], want.port0);
                compare_field("port1_value", o_m_axis_tdata[23:16], want.port1);
            end
        end
        i_m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        do @(posedge i_clk); while (stall_cycles < STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    task automatic test_hand_controllers();
        bus_read(ADDR_PORT_LO);
        bus_read(4'd0);
        send_plain(OP_TICK);
        set_pad(1'b0, 5'd0, 8'h01);
        set_pad(1'b0, 5'd14, 8'h80);
        set_pad(1'b1, 5'd15, 8'h04);
        set_pad(1'b1, HAND_LAST, 8'hF0);
        // entry index past the disc flags is dropped but still marks a change
        set_pad(1'b1, 5'd31, 8'hFF);
        send_plain(OP_TICK);
        bus_read(4'd15);
        send_plain(3'd7);
    endtask

    task automatic test_port_directions();
        bus_write(ADDR_CTRL, 8'hC0);
        bus_write(ADDR_PORT_LO, 8'h00);
        bus_write(4'd3, 8'hFF);
        bus_read(4'd13);
        // both ports back to input forces a fresh evaluation
        bus_write(ADDR_CTRL, 8'h00);
        bus_read(4'd15);
    endtask

    task automatic test_keyboard_matrix();
        drain_results();
        set_pad_mode(1'b1);
        set_row(3'd0, 24'h000201);
        set_row(3'd7, 24'hFF0080);
        bus_write(ADDR_CTRL, 8'h40);
        bus_write(ADDR_PORT_LO, 8'hFE);
        // fake shift sequence over two scans
        bus_read(4'd15);
        bus_read(4'd15);
        bus_write(ADDR_CTRL, 8'h80);
        bus_read(ADDR_PORT_LO);
        bus_write(ADDR_CTRL, 8'hC0);
        bus_read(ADDR_PORT_LO);
        set_row(3'd7, 24'hFFFFFF);
        send_plain(OP_TICK);
    endtask

    task automatic run_traffic(int items, logic mode, int send_gap, int take_gap);
        drain_results();
        set_pad_mode(mode);
        src_idle_pct = send_gap;
        snk_idle_pct = take_gap;
        for (int n = 0; n < items; n++) begin
            if (n == items / 2)
                drain_results();
            send_item(traffic_item());
        end
        drain_results();
    endtask

    task automatic test_random_traffic();
        run_traffic(175, 1'b0, 21, 57);
        run_traffic(175, 1'b1, 21, 57);
        run_traffic(175, 1'b1, 57, 21);
        run_traffic(175, 1'b0, 57, 21);
        run_traffic(175, 1'b0, 0, 0);
        run_traffic(175, 1'b1, 0, 0);
    endtask

    initial begin
        clear_ports_model();
        src_idle_pct = 21;
        snk_idle_pct = 57;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_pad_mode(1'b0);
        test_hand_controllers();
        test_port_directions();
        test_keyboard_matrix();
        test_random_traffic();
        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
